FILE: hdl/mqf_pkg.sv
`default_nettype none

package mqf_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;

  localparam int CLIENT_W  = 16;
  localparam int QIDX_W    = 8;
  localparam int ACTIVE_W  = 4;
  localparam int STATUS_W  = 3;

  localparam int QNUM_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HEAD_W    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  localparam int CQ_DEPTH  = 2;
  localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);

  typedef enum logic [0:0] {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } mqf_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ    = 3'd0,
    ST_DEQ    = 3'd1,
    ST_BADIDX = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4
  } mqf_status_e;

  typedef struct packed {
    mqf_func_e           op;
    logic                bad;
    logic [QNUM_W-1:0]   qnum;
    logic [ID_WIDTH-1:0] client_id;
  } mqf_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/multi_queue_fifo_manager.sv
// path: an accepted item is stored in the command queue, then its result is registered at the output
// throughput: one item per cycle while neither side stalls, one queue's pointers and one entry touched per item
// a two-entry command queue separates classification from the queue pointer/store update
// reset: all queues empty, head pointers zero, active count eight; entry store not cleared
`default_nettype none

module multi_queue_fifo_manager import mqf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [ACTIVE_W-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [0:0]          func_i,
  input  wire logic [QIDX_W-1:0]   queue_index_i,
  input  wire logic [CLIENT_W-1:0] client_id_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [CLIENT_W-1:0]      exit_client_o
);

  logic     cq_full;
  logic     cq_push;
  mqf_cmd_t cq_in;
  logic     cq_valid;
  logic     cq_pop;
  mqf_cmd_t cq_out;

  mqf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .queue_index_i (queue_index_i),
    .client_id_i   (client_id_i),
    .cq_full_i     (cq_full),
    .cq_push_o     (cq_push),
    .cq_cmd_o      (cq_in)
  );

  mqf_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .cmd_i   (cq_in),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .valid_o (cq_valid),
    .cmd_o   (cq_out)
  );

  mqf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cq_valid),
    .cmd_i         (cq_out),
    .cmd_pop_o     (cq_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .exit_client_o (exit_client_o)
  );

  a_exit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_DEQ) |-> (exit_client_o == '0))
    else $error("exit client nonzero on a non-dequeue result");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop |-> cq_valid)
    else $error("command queue popped while empty");

  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_pop |-> (!out_valid_o || !out_stall_i))
    else $error("command popped while output register is held");

endmodule

`default_nettype wire

FILE: hdl/mqf_front.sv
`default_nettype none

module mqf_front import mqf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [ACTIVE_W-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [0:0]          func_i,
  input  wire logic [QIDX_W-1:0]   queue_index_i,
  input  wire logic [CLIENT_W-1:0] client_id_i,
  input  wire logic                cq_full_i,
  output logic                     cq_push_o,
  output mqf_cmd_t                 cq_cmd_o
);

  logic [ACTIVE_W-1:0] active_q, active_d;
  logic [QIDX_W-1:0]   eff_count;
  logic                bad;
  logic [QIDX_W-1:0]   qi_minus1;

  always_comb begin
    active_d = cfg_we_i ? cfg_wdata_i : active_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else begin
      active_q <= active_d;
    end
  end

  // clamp active count to the number of queues built
  always_comb begin
    if (32'(active_q) > NUM_QUEUES) begin
      eff_count = QIDX_W'(NUM_QUEUES);
    end else begin
      eff_count = QIDX_W'(active_q);
    end
    bad       = (queue_index_i == '0) || (queue_index_i > eff_count);
    qi_minus1 = queue_index_i - QIDX_W'(1);
  end

  always_comb begin
    cq_cmd_o.op        = mqf_func_e'(func_i);
    cq_cmd_o.bad       = bad;
    cq_cmd_o.qnum      = bad ? '0 : QNUM_W'(qi_minus1);
    cq_cmd_o.client_id = ID_WIDTH'(client_id_i);
  end

  assign in_stall_o = cq_full_i;
  assign cq_push_o  = in_valid_i && !cq_full_i;

endmodule

`default_nettype wire

FILE: hdl/mqf_cmd_queue.sv
`default_nettype none

module mqf_cmd_queue import mqf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire mqf_cmd_t cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output mqf_cmd_t      cmd_o
);

  mqf_cmd_t              slot_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0]   cnt_q, cnt_d;

  function automatic logic [CQ_PTR_W-1:0] ptr_inc(input logic [CQ_PTR_W-1:0] p);
    logic [CQ_PTR_W-1:0] r;
    if (32'(p) == CQ_DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + CQ_PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CQ_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (32'(cnt_q) == CQ_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: hdl/mqf_back.sv
`default_nettype none

module mqf_back import mqf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire mqf_cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [CLIENT_W-1:0]      exit_client_o
);

  logic [HEAD_W-1:0]   head_q [NUM_QUEUES];
  logic [FILL_W-1:0]   fill_q [NUM_QUEUES];
  logic [ID_WIDTH-1:0] mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] rd_q;
  logic                out_valid_q, out_valid_d;
  mqf_status_e         status_q, status_d;

  logic                pop;
  logic [HEAD_W-1:0]   cur_head;
  logic [FILL_W-1:0]   cur_fill;
  logic [FILL_W:0]     tail_sum;
  logic [HEAD_W-1:0]   tail_slot;
  logic [HEAD_W-1:0]   next_head;
  logic [HEAD_W-1:0]   slot;
  logic [ADDR_W-1:0]   addr;

  assign pop = cmd_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    cur_head = head_q[cmd_i.qnum];
    cur_fill = fill_q[cmd_i.qnum];
    tail_sum = (FILL_W+1)'(cur_head) + (FILL_W+1)'(cur_fill);
    if (32'(tail_sum) >= QUEUE_DEPTH) begin
      tail_slot = HEAD_W'(32'(tail_sum) - QUEUE_DEPTH);
    end else begin
      tail_slot = HEAD_W'(tail_sum);
    end
    if (32'(cur_head) == QUEUE_DEPTH - 1) begin
      next_head = '0;
    end else begin
      next_head = cur_head + HEAD_W'(1);
    end
    slot = (cmd_i.op == FUNC_ENQ) ? tail_slot : cur_head;
    addr = ADDR_W'(32'(cmd_i.qnum) * QUEUE_DEPTH + 32'(slot));
  end

  always_comb begin
    if (cmd_i.bad) begin
      status_d = ST_BADIDX;
    end else if (cmd_i.op == FUNC_ENQ) begin
      status_d = (32'(cur_fill) >= QUEUE_DEPTH) ? ST_FULL : ST_ENQ;
    end else begin
      status_d = (cur_fill == '0) ? ST_EMPTY : ST_DEQ;
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      status_q    <= ST_ENQ;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        status_q <= status_d;
        if (status_d == ST_ENQ) begin
          fill_q[cmd_i.qnum] <= cur_fill + FILL_W'(1);
        end else if (status_d == ST_DEQ) begin
          head_q[cmd_i.qnum] <= next_head;
          fill_q[cmd_i.qnum] <= cur_fill - FILL_W'(1);
        end
      end
    end
  end

  // entry store, registered read
  always_ff @(posedge clk_i) begin
    if (pop && status_d == ST_ENQ) begin
      mem[addr] <= cmd_i.client_id;
    end
    if (pop) begin
      rd_q <= mem[addr];
    end
  end

  assign cmd_pop_o     = pop;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign exit_client_o = (status_q == ST_DEQ) ? CLIENT_W'(rd_q) : '0;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
  import mqf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_PHASES     = 6;

  typedef struct packed {
    mqf_status_e         status;
    logic [CLIENT_W-1:0] exit_id;
  } exit_rec_t;

  class queue_shadow;
    logic [ID_WIDTH-1:0] slots [NUM_QUEUES*QUEUE_DEPTH];
    logic [HEAD_W-1:0]   heads [NUM_QUEUES];
    logic [FILL_W-1:0]   fills [NUM_QUEUES];
    logic [ACTIVE_W-1:0] active_cnt;
    exit_rec_t           exits_due[$];
    int                  mismatches;

    function new();
      foreach (heads[i]) begin
        heads[i] = '0;
        fills[i] = '0;
      end
      active_cnt = ACTIVE_RESET;
      mismatches = 0;
    endfunction

    function void note_command(mqf_func_e op, logic [QIDX_W-1:0] qidx,
                               logic [CLIENT_W-1:0] cid);
      exit_rec_t rec;
      int lim;
      int q;
      int slot;
      lim = (int'(active_cnt) > NUM_QUEUES) ? NUM_QUEUES : int'(active_cnt);
      rec.exit_id = '0;
      if (qidx == 0 || int'(qidx) > lim) begin
        rec.status = ST_BADIDX;
      end else begin
        q = int'(qidx) - 1;
        if (op == FUNC_ENQ) begin
          if (fills[q] >= QUEUE_DEPTH) begin
            rec.status = ST_FULL;
          end else begin
            slot = (int'(heads[q]) + int'(fills[q])) % QUEUE_DEPTH;
            slots[q*QUEUE_DEPTH + slot] = ID_WIDTH'(cid);
            fills[q] = fills[q] + 1'b1;
            rec.status = ST_ENQ;
          end
        end else if (fills[q] == 0) begin
          rec.status = ST_EMPTY;
        end else begin
          slot = int'(heads[q]);
          rec.exit_id = CLIENT_W'(slots[q*QUEUE_DEPTH + slot]);
          heads[q] = HEAD_W'((slot + 1) % QUEUE_DEPTH);
          fills[q] = fills[q] - 1'b1;
          rec.status = ST_DEQ;
        end
      end
      exits_due.push_back(rec);
    endfunction

    function void check_exit(logic [STATUS_W-1:0] st, logic [CLIENT_W-1:0] ex);
      exit_rec_t rec;
      if (exits_due.size() == 0) begin
        $error("unexpected result: status %0d exit_client 0x%0h", st, ex);
        mismatches++;
        return;
      end
      rec = exits_due.pop_front();
      if (st !== rec.status) begin
        $error("status: expected %0d, got %0d", rec.status, st);
        mismatches++;
      end
      if (ex !== rec.exit_id) begin
        $error("exit_client: expected 0x%0h, got 0x%0h", rec.exit_id, ex);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [ACTIVE_W-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [0:0]          func_i;
  logic [QIDX_W-1:0]   queue_index_i;
  logic [CLIENT_W-1:0] client_id_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [CLIENT_W-1:0] exit_client_o;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stuck_cycles = 0;

  queue_shadow shadow;

  multi_queue_fifo_manager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .queue_index_i (queue_index_i),
    .client_id_i   (client_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .exit_client_o (exit_client_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver side, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        shadow.note_command(mqf_func_e'(func_i), queue_index_i, client_id_i);
      end
      if (out_valid_o && !out_stall_i) begin
        shadow.check_exit(status_o, exit_client_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic send_cmd(mqf_func_e op, logic [QIDX_W-1:0] qidx,
                          logic [CLIENT_W-1:0] cid);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= op;
    queue_index_i <= qidx;
    client_id_i   <= cid;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    // let the last accepted item reach the scoreboard first
    @(posedge clk_i);
    while (shadow.exits_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_active(logic [ACTIVE_W-1:0] cnt);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.active_cnt = cnt;
  endtask

  task automatic run_phase(int n, logic [ACTIVE_W-1:0] cnt, bit stress);
    int lim;
    int lean;
    int pick;
    mqf_func_e op;
    logic [QIDX_W-1:0] qidx;
    logic [CLIENT_W-1:0] cid;
    set_active(cnt);
    lim = (int'(cnt) > NUM_QUEUES) ? NUM_QUEUES : int'(cnt);
    lean = 2;
    for (int i = 0; i < n; i++) begin
      if (i % 24 == 0) lean = $urandom_range(2);
      if (stress) begin
        calm = (i >= 150 && i < 300);
        if (i == 350) hold_req = 1'b1;
      end
      pick = $urandom_range(99);
      case (lean)
        0: op = (pick < 80) ? FUNC_ENQ : FUNC_DEQ;
        1: op = (pick < 80) ? FUNC_DEQ : FUNC_ENQ;
        default: op = (pick < 50) ? FUNC_ENQ : FUNC_DEQ;
      endcase
      if (lim == 0 || $urandom_range(99) < 10) begin
        qidx = QIDX_W'($urandom_range(255));
      end else begin
        qidx = QIDX_W'($urandom_range(lim, 1));
      end
      pick = $urandom_range(99);
      if (pick < 10) cid = '1;
      else if (pick < 15) cid = '0;
      else cid = CLIENT_W'($urandom);
      send_cmd(op, qidx, cid);
    end
    calm = 1'b0;
  endtask

  int unsigned         phase_items [NUM_PHASES] = '{450, 200, 400, 40, 300, 300};
  logic [ACTIVE_W-1:0] phase_cnt   [NUM_PHASES] = '{8, 1, 5, 0, 15, 2};

  initial begin
    shadow        = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_ENQ;
    queue_index_i = '0;
    client_id_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(FUNC_DEQ, 8'd1, 16'h1234);
    send_cmd(FUNC_ENQ, 8'd1, 16'h0000);
    send_cmd(FUNC_ENQ, 8'd8, 16'hFFFF);
    send_cmd(FUNC_ENQ, 8'd0, 16'hAAAA);
    send_cmd(FUNC_DEQ, 8'd255, 16'h5555);
    send_cmd(FUNC_DEQ, 8'd1, 16'h0000);
    send_cmd(FUNC_DEQ, 8'd8, 16'h0000);
    // fill one queue past its depth
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      send_cmd(FUNC_ENQ, 8'd3, CLIENT_W'(16'hC000 + i));
    end
    send_cmd(FUNC_DEQ, 8'd3, 16'h0000);
    set_active(4'd1);
    send_cmd(FUNC_ENQ, 8'd3, 16'h0F0F);
    send_cmd(FUNC_DEQ, 8'd1, 16'h0000);
    set_active(4'd0);
    send_cmd(FUNC_ENQ, 8'd1, 16'hF0F0);
    // counts above the queue total act as the total
    set_active(4'd15);
    send_cmd(FUNC_ENQ, 8'd9, 16'h7FFF);
    send_cmd(FUNC_DEQ, 8'd3, 16'h0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(phase_items[p], phase_cnt[p], p == 0);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (shadow.exits_due.size() != 0) begin
      $error("%0d results never arrived", shadow.exits_due.size());
    end
    if (shadow.mismatches == 0 && shadow.exits_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
